// ===== rtl/core/fpaf_pkg.sv =====
package fpaf_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int POS_W     = 12;
    localparam int LEN_W     = 13;
    localparam int RATE_W    = 20;
    localparam int MAX_FRAME = 4096;
    localparam int Q_DEPTH   = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_SAMPLING_RATE  = 2'd0;
    localparam logic [1:0] CFG_FRAME_LENGTH   = 2'd1;
    localparam logic [1:0] CFG_ZERO_LEVEL     = 2'd2;
    localparam logic [1:0] CFG_PEAK_THRESHOLD = 2'd3;

    localparam logic [RATE_W-1:0]   SAMPLING_RATE_RST  = 20'd8000;
    localparam logic [LEN_W-1:0]    FRAME_LENGTH_RST   = 13'd256;
    localparam logic [SAMPLE_W-1:0] ZERO_LEVEL_RST     = 10'd512;
    localparam logic [SAMPLE_W-1:0] PEAK_THRESHOLD_RST = 10'd600;

    typedef struct packed {
        logic [RATE_W-1:0]   sampling_rate;
        logic [LEN_W-1:0]    frame_length;
        logic [SAMPLE_W-1:0] zero_level;
        logic [SAMPLE_W-1:0] peak_threshold;
    } t_cfg;

    // per-frame summary handed from the front end to the divider
    typedef struct packed {
        logic [SAMPLE_W-1:0] amplitude;
        logic [POS_W-1:0]    period;
        logic                valid;
    } t_frame_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ===== rtl/core/fpaf_front.sv =====
module fpaf_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [fpaf_pkg::SAMPLE_W-1:0]     i_sample,
    input  fpaf_pkg::t_cfg                    i_cfg,
    output logic                              o_push,
    output fpaf_pkg::t_frame_rec              o_rec
);

    localparam logic [1:0] PEAKS_NONE = 2'd0;
    localparam logic [1:0] PEAKS_ONE  = 2'd1;
    localparam logic [1:0] PEAKS_TWO  = 2'd2;

    logic [fpaf_pkg::POS_W-1:0]    r_count, n_count;
    logic                          r_crossed, n_crossed;
    logic [fpaf_pkg::SAMPLE_W-1:0] r_peak_val, n_peak_val;
    logic [fpaf_pkg::POS_W-1:0]    r_peak_pos, n_peak_pos;
    logic [fpaf_pkg::POS_W-1:0]    r_prev_pos, n_prev_pos;
    logic [1:0]                    r_peaks, n_peaks;
    logic [fpaf_pkg::SAMPLE_W-1:0] r_avg_amp, n_avg_amp;
    logic [fpaf_pkg::POS_W-1:0]    r_avg_per, n_avg_per;

    logic [fpaf_pkg::POS_W-1:0]    spacing;
    logic [fpaf_pkg::SAMPLE_W:0]   amp_sum;
    logic [fpaf_pkg::POS_W:0]      per_sum;
    logic [fpaf_pkg::LEN_W-1:0]    eff_len;
    logic [fpaf_pkg::LEN_W-1:0]    next_idx;
    logic                          frame_end;
    logic                          rec_valid;

    assign spacing = r_peak_pos - r_prev_pos;
    assign amp_sum = {1'b0, r_avg_amp} + {1'b0, r_peak_val};
    assign per_sum = {1'b0, r_avg_per} + {1'b0, spacing};

    always_comb begin
        if (i_cfg.frame_length == '0) begin
            eff_len = fpaf_pkg::LEN_W'(1);
        end else if (i_cfg.frame_length > fpaf_pkg::LEN_W'(fpaf_pkg::MAX_FRAME)) begin
            eff_len = fpaf_pkg::LEN_W'(fpaf_pkg::MAX_FRAME);
        end else begin
            eff_len = i_cfg.frame_length;
        end
    end

    assign next_idx  = {1'b0, r_count} + fpaf_pkg::LEN_W'(1);
    assign frame_end = (next_idx >= eff_len);

    always_comb begin
        n_crossed  = r_crossed;
        n_peak_val = r_peak_val;
        n_peak_pos = r_peak_pos;
        n_prev_pos = r_prev_pos;
        n_peaks    = r_peaks;
        n_avg_amp  = r_avg_amp;
        n_avg_per  = r_avg_per;

        if (!r_crossed) begin
            if (i_sample <= i_cfg.zero_level) begin
                n_crossed  = 1'b1;
                n_peak_val = i_sample;
                n_peak_pos = r_count;
            end
        end else if (i_sample > r_peak_val) begin
            n_peak_val = i_sample;
            n_peak_pos = r_count;
        end else if (i_sample <= i_cfg.zero_level && r_peak_val >= i_cfg.peak_threshold) begin
            // close the peak; the closing sample seeds the next search
            case (r_peaks)
                PEAKS_NONE: begin
                    n_avg_amp = r_peak_val;
                    n_peaks   = PEAKS_ONE;
                end
                PEAKS_ONE: begin
                    n_avg_amp = amp_sum[fpaf_pkg::SAMPLE_W:1];
                    n_avg_per = spacing;
                    n_peaks   = PEAKS_TWO;
                end
                default: begin
                    n_avg_amp = amp_sum[fpaf_pkg::SAMPLE_W:1];
                    n_avg_per = per_sum[fpaf_pkg::POS_W:1];
                end
            endcase
            n_prev_pos = r_peak_pos;
            n_peak_pos = r_count;
            n_peak_val = i_sample;
        end

        n_count = frame_end ? '0 : next_idx[fpaf_pkg::POS_W-1:0];
    end

    assign rec_valid       = (n_peaks == PEAKS_TWO) && (n_avg_per != '0);
    assign o_push          = i_accept && frame_end;
    assign o_rec.amplitude = (n_peaks == PEAKS_NONE) ? i_cfg.zero_level : n_avg_amp;
    assign o_rec.period    = rec_valid ? n_avg_per : '0;
    assign o_rec.valid     = rec_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_crossed  <= 1'b0;
            r_peak_val <= '0;
            r_peak_pos <= '0;
            r_prev_pos <= '0;
            r_peaks    <= PEAKS_NONE;
            r_avg_amp  <= fpaf_pkg::ZERO_LEVEL_RST;
            r_avg_per  <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
            if (frame_end) begin
                r_crossed  <= 1'b0;
                r_peak_val <= '0;
                r_peak_pos <= '0;
                r_prev_pos <= '0;
                r_peaks    <= PEAKS_NONE;
                r_avg_amp  <= i_cfg.zero_level;
                r_avg_per  <= '0;
            end else begin
                r_crossed  <= n_crossed;
                r_peak_val <= n_peak_val;
                r_peak_pos <= n_peak_pos;
                r_prev_pos <= n_prev_pos;
                r_peaks    <= n_peaks;
                r_avg_amp  <= n_avg_amp;
                r_avg_per  <= n_avg_per;
            end
        end
    end

endmodule

// ===== rtl/core/fpaf_queue.sv =====
module fpaf_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  fpaf_pkg::t_frame_rec      i_rec,
    input  logic                      i_pop,
    output fpaf_pkg::t_frame_rec      o_rec,
    output fpaf_pkg::t_queue_status   o_status
);

    localparam int PTR_W = $clog2(fpaf_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(fpaf_pkg::Q_DEPTH + 1);

    fpaf_pkg::t_frame_rec r_mem [fpaf_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_status.full  = (r_cnt == CNT_W'(fpaf_pkg::Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_rec          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/fpaf_back.sv =====
module fpaf_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fpaf_pkg::t_frame_rec              i_rec,
    input  logic                              i_empty,
    input  logic [fpaf_pkg::RATE_W-1:0]       i_sampling_rate,
    output logic                              o_pop,
    output logic                              o_result_valid,
    input  logic                              i_result_ready,
    output logic [fpaf_pkg::SAMPLE_W-1:0]     o_amplitude,
    output logic [fpaf_pkg::POS_W-1:0]        o_period,
    output logic [fpaf_pkg::RATE_W-1:0]       o_frequency,
    output logic                              o_frequency_valid
);

    localparam int STEP_W = $clog2(fpaf_pkg::RATE_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic [STEP_W-1:0]             r_step;
    logic [fpaf_pkg::POS_W-1:0]    r_rem;
    logic [fpaf_pkg::RATE_W-1:0]   r_quo;
    fpaf_pkg::t_frame_rec          r_rec;
    logic                          r_out_valid;
    logic [fpaf_pkg::SAMPLE_W-1:0] r_out_amp;
    logic [fpaf_pkg::POS_W-1:0]    r_out_per;
    logic [fpaf_pkg::RATE_W-1:0]   r_out_freq;
    logic                          r_out_fvalid;

    logic [fpaf_pkg::POS_W:0]      rem_sh;
    logic                          q_bit;
    logic                          out_free;
    logic                          load_out;

    // restoring division, one quotient bit per cycle
    assign rem_sh   = {r_rem, r_quo[fpaf_pkg::RATE_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, r_rec.period});
    assign out_free = !r_out_valid || i_result_ready;
    assign o_pop    = (r_state == ST_IDLE) && !i_empty;
    assign load_out = (r_state == ST_HOLD) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = i_rec.valid ? ST_DIV : ST_HOLD;
                end
            end
            ST_DIV: begin
                if (r_step == STEP_W'(fpaf_pkg::RATE_W - 1)) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DIV) begin
                r_step <= r_step + STEP_W'(1);
            end else begin
                r_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
            r_rem <= '0;
            r_quo <= i_rec.valid ? i_sampling_rate : '0;
        end else if (r_state == ST_DIV) begin
            r_rem <= q_bit ? fpaf_pkg::POS_W'(rem_sh - {1'b0, r_rec.period})
                           : rem_sh[fpaf_pkg::POS_W-1:0];
            r_quo <= {r_quo[fpaf_pkg::RATE_W-2:0], q_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_result_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_amp    <= r_rec.amplitude;
            r_out_per    <= r_rec.period;
            r_out_freq   <= r_quo;
            r_out_fvalid <= r_rec.valid;
        end
    end

    assign o_result_valid    = r_out_valid;
    assign o_amplitude       = r_out_amp;
    assign o_period          = r_out_per;
    assign o_frequency       = r_out_freq;
    assign o_frequency_valid = r_out_fvalid;

endmodule

// ===== rtl/core/frame_peak_amplitude_frequency_top.sv =====
// Samples are taken at one per cycle; o_sample_ready drops only while the result queue is full.
// From the last sample of a frame, the record goes through the result queue to the back end;
// frames with two or more peaks and a nonzero period pass the bit-serial divider first.
// The back end takes one record at a time and pops the next only after loading the output
// register, so frames with a division are the slowest and the shared divider sets the pace.
// Reset (i_rst_n low, synchronous): registers return to 8000/256/512/600, frame state and
// queue are cleared, no result pending.
module frame_peak_amplitude_frequency_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_sample_valid,
    output logic                              o_sample_ready,
    input  logic [fpaf_pkg::SAMPLE_W-1:0]     i_sample,
    output logic                              o_result_valid,
    input  logic                              i_result_ready,
    output logic [fpaf_pkg::SAMPLE_W-1:0]     o_amplitude,
    output logic [fpaf_pkg::POS_W-1:0]        o_period,
    output logic [fpaf_pkg::RATE_W-1:0]       o_frequency,
    output logic                              o_frequency_valid,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [fpaf_pkg::RATE_W-1:0]       i_cfg_data
);

    fpaf_pkg::t_cfg          r_cfg;
    fpaf_pkg::t_frame_rec    push_rec, head_rec;
    fpaf_pkg::t_queue_status q_status;
    logic                    sample_acc;
    logic                    push;
    logic                    pop;

    assign o_cfg_ready    = 1'b1;
    assign o_sample_ready = !q_status.full;
    assign sample_acc     = i_sample_valid && o_sample_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sampling_rate  <= fpaf_pkg::SAMPLING_RATE_RST;
            r_cfg.frame_length   <= fpaf_pkg::FRAME_LENGTH_RST;
            r_cfg.zero_level     <= fpaf_pkg::ZERO_LEVEL_RST;
            r_cfg.peak_threshold <= fpaf_pkg::PEAK_THRESHOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                fpaf_pkg::CFG_SAMPLING_RATE: r_cfg.sampling_rate <= i_cfg_data;
                fpaf_pkg::CFG_FRAME_LENGTH:
                    r_cfg.frame_length <= i_cfg_data[fpaf_pkg::LEN_W-1:0];
                fpaf_pkg::CFG_ZERO_LEVEL:
                    r_cfg.zero_level <= i_cfg_data[fpaf_pkg::SAMPLE_W-1:0];
                fpaf_pkg::CFG_PEAK_THRESHOLD:
                    r_cfg.peak_threshold <= i_cfg_data[fpaf_pkg::SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    fpaf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (sample_acc),
        .i_sample (i_sample),
        .i_cfg    (r_cfg),
        .o_push   (push),
        .o_rec    (push_rec)
    );

    fpaf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (push_rec),
        .i_pop    (pop),
        .o_rec    (head_rec),
        .o_status (q_status)
    );

    fpaf_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rec             (head_rec),
        .i_empty           (q_status.empty),
        .i_sampling_rate   (r_cfg.sampling_rate),
        .o_pop             (pop),
        .o_result_valid    (o_result_valid),
        .i_result_ready    (i_result_ready),
        .o_amplitude       (o_amplitude),
        .o_period          (o_period),
        .o_frequency       (o_frequency),
        .o_frequency_valid (o_frequency_valid)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("frame record pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("frame record popped from empty queue");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_frequency_valid) |-> (o_period == '0 && o_frequency == '0))
        else $error("invalid result carries nonzero period or frequency");

    a_valid_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_frequency_valid) |-> (o_period != '0))
        else $error("valid result with zero period");

endmodule
